[src/swl_pkg.sv]
package swl_pkg;

	// Frame geometry
	localparam int DATA_BITS = 8;
	localparam int BIT_IDX_W = $clog2(DATA_BITS + 3);
	localparam int SH_IDX_W  = $clog2(DATA_BITS);
	localparam int TICK_W    = 16;
	localparam int BYTE_W    = 8;

	// Bus widths
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;

	localparam logic [TICK_W-1:0] BIT_TICKS_RST = 16'd10;
	localparam logic [TICK_W-1:0] BIT_TICKS_MIN = 16'd2;

	// Phase codes
	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_TX         = 3'd1;
	localparam logic [2:0] PH_TX_ACKWAIT = 3'd2;
	localparam logic [2:0] PH_RX_START   = 3'd3;
	localparam logic [2:0] PH_RX_DATA    = 3'd4;
	localparam logic [2:0] PH_RX_STOP    = 3'd5;
	localparam logic [2:0] PH_RX_GAP     = 3'd6;
	localparam logic [2:0] PH_RX_ACK     = 3'd7;

	// One result item
	typedef struct packed {
		logic              tx_acked;
		logic              tx_done;
		logic              rx_frame_error;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_valid;
		logic              busy_res;
		logic              drive_low;
	} swl_res_t;

	// Pack a result item, drive_low in bit 0, zero filled to the bus width
	function automatic logic [M_TDATA_W-1:0] swl_pack(input swl_res_t r);
		return M_TDATA_W'(r);
	endfunction

endpackage

[src/swl_core.sv]
module swl_core
	import swl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [TICK_W-1:0] cfg_wr_data,
	input  logic              accept,
	input  logic              line_level,
	input  logic              send_request,
	input  logic [BYTE_W-1:0] send_byte,
	output swl_res_t          res
);

	logic [TICK_W-1:0]    bit_ticks_q;
	logic [2:0]           phase_q, phase_n;
	logic [TICK_W-1:0]    tick_q, tick_n;
	logic [BIT_IDX_W-1:0] idx_q, idx_n;
	logic [DATA_BITS-1:0] shift_q, shift_n;

	logic [TICK_W-1:0] full_ticks;
	logic [TICK_W-1:0] half_ticks;
	logic [TICK_W:0]   tick_inc;
	logic              full_hit;
	logic              half_hit;

	// Line drive while sending: low start, inverted data, released stop
	function automatic logic tx_drive(input logic [BIT_IDX_W-1:0] idx,
		input logic [DATA_BITS-1:0] sh);
		logic [BIT_IDX_W-1:0] m;
		m = idx - BIT_IDX_W'(1);
		if (idx == '0)
			return 1'b1;
		else if (idx <= BIT_IDX_W'(DATA_BITS))
			return ~sh[m[SH_IDX_W-1:0]];
		else
			return 1'b0;
	endfunction

	// Hold the bit period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= BIT_TICKS_RST;
		end else if (cfg_wr_en) begin
			bit_ticks_q <= cfg_wr_data;
		end
	end

	// Clamp the period and derive the half bit
	assign full_ticks = (bit_ticks_q < BIT_TICKS_MIN) ? BIT_TICKS_MIN : bit_ticks_q;
	assign half_ticks = full_ticks >> 1;
	assign tick_inc   = {1'b0, tick_q} + (TICK_W+1)'(1);
	assign full_hit   = tick_inc >= {1'b0, full_ticks};
	assign half_hit   = tick_inc >= {1'b0, half_ticks};

	// Advance the link state for one tick
	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		idx_n   = idx_q;
		shift_n = shift_q;
		res     = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (send_request) begin
					shift_n       = DATA_BITS'(send_byte);
					idx_n         = '0;
					tick_n        = '0;
					phase_n       = PH_TX;
					res.drive_low = 1'b1;
				end else if (!line_level) begin
					tick_n  = '0;
					phase_n = PH_RX_START;
				end
			end
			PH_TX: begin
				tick_n = tick_inc[TICK_W-1:0];
				if (full_hit) begin
					tick_n = '0;
					idx_n  = idx_q + BIT_IDX_W'(1);
				end
				if (idx_n > BIT_IDX_W'(DATA_BITS + 1)) begin
					phase_n = PH_TX_ACKWAIT;
					tick_n  = '0;
					idx_n   = '0;
				end else begin
					res.drive_low = tx_drive(idx_n, shift_q);
				end
			end
			PH_TX_ACKWAIT: begin
				tick_n = tick_inc[TICK_W-1:0];
				if (half_hit) begin
					res.tx_done  = 1'b1;
					res.tx_acked = ~line_level;
					tick_n       = '0;
					phase_n      = PH_IDLE;
				end
			end
			PH_RX_START: begin
				tick_n = tick_inc[TICK_W-1:0];
				if (half_hit) begin
					tick_n = '0;
					if (!line_level) begin
						idx_n   = '0;
						shift_n = '0;
						phase_n = PH_RX_DATA;
					end else begin
						phase_n = PH_IDLE;
					end
				end
			end
			PH_RX_DATA: begin
				tick_n = tick_inc[TICK_W-1:0];
				if (full_hit) begin
					tick_n  = '0;
					shift_n = {line_level, shift_q[DATA_BITS-1:1]};
					idx_n   = idx_q + BIT_IDX_W'(1);
					if (idx_n >= BIT_IDX_W'(DATA_BITS)) begin
						idx_n   = '0;
						phase_n = PH_RX_STOP;
					end
				end
			end
			PH_RX_STOP: begin
				tick_n = tick_inc[TICK_W-1:0];
				if (full_hit) begin
					tick_n = '0;
					if (line_level) begin
						phase_n = PH_RX_GAP;
					end else begin
						res.rx_frame_error = 1'b1;
						phase_n            = PH_IDLE;
					end
				end
			end
			PH_RX_GAP: begin
				tick_n = tick_inc[TICK_W-1:0];
				if (half_hit) begin
					tick_n        = '0;
					phase_n       = PH_RX_ACK;
					res.drive_low = 1'b1;
				end
			end
			PH_RX_ACK: begin
				tick_n = tick_inc[TICK_W-1:0];
				if (full_hit) begin
					tick_n       = '0;
					res.rx_valid = 1'b1;
					res.rx_byte  = BYTE_W'(shift_q);
					phase_n      = PH_IDLE;
				end else begin
					res.drive_low = 1'b1;
				end
			end
		endcase
		res.busy_res = !((phase_q == PH_IDLE) && (phase_n == PH_IDLE));
	end

	// Commit the state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			idx_q   <= '0;
			shift_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			idx_q   <= idx_n;
			shift_q <= shift_n;
		end
	end

endmodule

[src/swl_skid.sv]
module swl_skid
	import swl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  swl_res_t in_res,
	output logic     out_valid,
	input  logic     out_ready,
	output swl_res_t out_res
);

	logic     out_v_q;
	logic     skid_v_q;
	swl_res_t out_q;
	swl_res_t skid_q;
	logic     take;
	logic     drain;

	assign in_ready  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign take      = in_valid && in_ready;
	assign drain     = out_v_q && out_ready;

	// Track occupancy of the output and skid stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (drain)
					skid_v_q <= 1'b0;
			end else if (take) begin
				if (!out_v_q || drain)
					out_v_q <= 1'b1;
				else
					skid_v_q <= 1'b1;
			end else if (drain) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Move item payloads
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (drain)
				out_q <= skid_q;
		end else if (take) begin
			if (!out_v_q || drain)
				out_q <= in_res;
			else
				skid_q <= in_res;
		end
	end

endmodule

[src/single_wire_serial_link_with_ack_top.sv]
// Half-duplex single-wire serial transceiver with acknowledge.
// s_* channel: one item per line tick, carrying the sampled line level, a
// send request and the byte to send. m_* channel: one result item per input
// item with the line drive, busy flag, receive and transmit status.
// The bit period is written through cfg_wr_en / cfg_wr_data (ticks per bit,
// values below 2 act as 2); write it only while the link is idle.
// The result of an item is registered in the output stage before it appears
// on m_tvalid. Throughput: one item per cycle while s_tready is high; the tick
// state machine computes its next state combinationally, so the next item is taken right away.
// A two-entry output stage (result register plus skid register) keeps
// s_tready high while one result waits; s_tready drops only when both are
// full, and rises again once the receiver takes an item.
// Reset (arst_n low) returns the link to idle, clears both output stages and
// loads a bit period of 10 ticks.
module single_wire_serial_link_with_ack_top
	import swl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [TICK_W-1:0]    cfg_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] line_level, [1] send_request, [9:2] send_byte, [15:10] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] drive_low, [1] busy_res, [2] rx_valid, [10:3] rx_byte,
	// [11] rx_frame_error, [12] tx_done, [13] tx_acked, [15:14] zero
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic     accept;
	swl_res_t core_res;
	swl_res_t out_res;

	assign accept = s_tvalid && s_tready;

	// Tick state machine
	swl_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.accept       (accept),
		.line_level   (s_tdata[0]),
		.send_request (s_tdata[1]),
		.send_byte    (s_tdata[9:2]),
		.res          (core_res)
	);

	// Output register with skid stage
	swl_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = swl_pack(out_res);

	// Receive completion and transmit completion never share an item
	a_no_rx_tx_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[12]))
		else $error("rx_valid and tx_done in the same item");

	// Line is only pulled low while busy
	a_drive_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> m_tdata[1])
		else $error("drive_low without busy_res");

	// Input stalls only when a result is waiting at the output
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("s_tready low with empty output stage");

	// A stalled input follows a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && s_tvalid && m_tvalid && !m_tready) |=> !s_tready)
		else $error("skid stage not filled on stall");

endmodule
